>>> src/mnahf_pkg.sv
// ----------------------------------------------------------------------------
// mnahf_pkg
// Shared types and constants of the masked neighbour-average hole fill unit:
// register indexes, command codes, pixel formats and field widths.
// ----------------------------------------------------------------------------
package mnahf_pkg;

  // default line store depth (pixels per row)
  localparam int DEF_MAX_WIDTH = 1024;

  // fixed field widths of the configuration registers
  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  // row range
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;

  // reset values of the registers
  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = WIDTH_CFG_W'(1024);
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = HEIGHT_CFG_W'(1024);

  // per-channel sum of eight neighbours
  localparam int SUM_W = 11;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // input command codes
  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_PAD   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // original pixel as kept in the pending ring
  typedef struct packed {
    logic painted;
    rgb_t rgb;
  } ring_entry_t;

  // control of an item in the neighbour stage
  typedef struct packed {
    logic emit;
    logic frame_last;
    logic has_l;
    logic has_r;
    logic has_u;
    logic has_d;
  } nb_ctrl_t;

endpackage

>>> src/masked_neighbor_average_hole_fill_unit.sv
// ----------------------------------------------------------------------------
// masked_neighbor_average_hole_fill_unit
// Streaming 3x3 hole fill: unpainted pixels become the neighbour sum >> 3.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while the output is not stalled. Each
// pixel is held in a pending ring of MAX_WIDTH+1 entries and leaves once
// image_width+1 later items have arrived; after being released it passes the
// stage one registers and then the output register. The rate is set
// by the two line stores (pending ring and finished line), each taking one
// write and two reads per cycle. At the end of a frame the host sends
// image_width+1 padding items; the last of them produces the final pixel with
// frame_end set and is itself discarded. Image width is used clamped to
// 1..MAX_WIDTH and image height to 1..4096; change them only between frames.
// ----------------------------------------------------------------------------
module masked_neighbor_average_hole_fill_unit
  import mnahf_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_command,
  input  logic [7:0]             in_red_in,
  input  logic [7:0]             in_green_in,
  input  logic [7:0]             in_blue_in,
  input  logic                   in_painted,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_red_out,
  output logic [7:0]             out_green_out,
  output logic [7:0]             out_blue_out,
  output logic                   out_frame_end
);

  localparam int RING_DEPTH = MAX_WIDTH + 1;
  localparam int CW = $clog2(MAX_WIDTH);      // column / line address
  localparam int PW = $clog2(RING_DEPTH);     // ring slot
  localparam int WW = $clog2(MAX_WIDTH + 1);  // effective width
  localparam int NW = $clog2(MAX_WIDTH + 2);  // pending count

  // configuration registers
  logic [WIDTH_CFG_W-1:0]  width_cfg_r;
  logic [HEIGHT_CFG_W-1:0] height_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= WIDTH_RESET;
      height_cfg_r <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_cfg_r  <= cfg_data[WIDTH_CFG_W-1:0];
        CFG_IMAGE_HEIGHT: height_cfg_r <= cfg_data[HEIGHT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  logic [WW-1:0]           w_eff;
  logic [HEIGHT_CFG_W-1:0] h_eff;

  always_comb begin
    if (width_cfg_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(width_cfg_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_cfg_r);
    end
    if (height_cfg_r == '0) begin
      h_eff = HEIGHT_CFG_W'(1);
    end else if (int'(height_cfg_r) > MAX_HEIGHT) begin
      h_eff = HEIGHT_CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_cfg_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage one: position tracking, ring write and line store reads
  // --------------------------------------------------------------------------
  logic [PW-1:0]    ws_r, ws_nxt;
  logic [NW-1:0]    pcnt_r, pcnt_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  rgb_t             last1_r, last2_r;

  logic        in_acc;
  logic        s1_adv;
  ring_entry_t in_pix;
  nb_ctrl_t    ctrl_nxt;
  logic        ring_we;

  logic [NW-1:0]           w_p1;
  logic [WW-1:0]           col_p1;
  logic [HEIGHT_CFG_W-1:0] row_p1;
  logic                    last_col;
  logic [PW:0]             right_diff, ctr_diff;
  logic [PW-1:0]           right_addr, ctr_addr;
  logic [CW-1:0]           line_a_addr, line_b_addr;

  assign in_acc = in_valid && in_ready;

  // padding items enter as unpainted zero pixels
  always_comb begin
    if (cmd_t'(in_command) == CMD_PAD) begin
      in_pix = '0;
    end else begin
      in_pix.painted   = in_painted;
      in_pix.rgb.red   = in_red_in;
      in_pix.rgb.green = in_green_in;
      in_pix.rgb.blue  = in_blue_in;
    end
  end

  // neighbour availability of the pixel that this item releases
  always_comb begin
    w_p1     = NW'(w_eff) + NW'(1);
    col_p1   = WW'(col_r) + WW'(1);
    row_p1   = HEIGHT_CFG_W'(row_r) + HEIGHT_CFG_W'(1);
    last_col = col_p1 >= w_eff;

    ctrl_nxt.emit       = pcnt_r >= w_p1;
    ctrl_nxt.has_l      = col_r != '0;
    ctrl_nxt.has_r      = !last_col;
    ctrl_nxt.has_u      = row_r != '0;
    ctrl_nxt.has_d      = row_p1 < h_eff;
    ctrl_nxt.frame_last = ctrl_nxt.emit && last_col && !ctrl_nxt.has_d;
  end

  // ring slots of the right neighbour and of the centre pixel
  always_comb begin
    right_diff = {1'b0, ws_r} - (PW+1)'(w_eff);
    ctr_diff   = {1'b0, ws_r} - (PW+1)'(w_eff) - (PW+1)'(1);
    right_addr = right_diff[PW] ? PW'(right_diff + (PW+1)'(RING_DEPTH)) : PW'(right_diff);
    ctr_addr   = ctr_diff[PW] ? PW'(ctr_diff + (PW+1)'(RING_DEPTH)) : PW'(ctr_diff);
  end

  // finished line: column itself and column to the right
  assign line_b_addr = col_r;
  assign line_a_addr = last_col ? col_r : CW'(col_p1);

  // position and fill count update
  always_comb begin
    ws_nxt   = ws_r;
    pcnt_nxt = pcnt_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    ring_we  = 1'b0;
    if (in_acc) begin
      ring_we = !ctrl_nxt.frame_last;
      if (ctrl_nxt.emit) begin
        if (last_col) begin
          col_nxt = '0;
          row_nxt = ctrl_nxt.frame_last ? '0 : ROW_W'(row_p1);
        end else begin
          col_nxt = CW'(col_p1);
        end
        if (ctrl_nxt.frame_last) begin
          pcnt_nxt = '0;
        end
      end else begin
        pcnt_nxt = pcnt_r + NW'(1);
      end
      if (ring_we) begin
        ws_nxt = (ws_r == PW'(RING_DEPTH - 1)) ? '0 : ws_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r    <= '0;
      pcnt_r  <= '0;
      col_r   <= '0;
      row_r   <= '0;
      last1_r <= '0;
      last2_r <= '0;
    end else begin
      ws_r   <= ws_nxt;
      pcnt_r <= pcnt_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      if (ring_we) begin
        last1_r <= in_pix.rgb;
        last2_r <= last1_r;
      end
    end
  end

  // pending ring of original pixels
  ring_entry_t ring_mem [RING_DEPTH];
  ring_entry_t center_r;
  rgb_t        right_r;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ws_r] <= in_pix;
    end
    if (in_acc) begin
      center_r <= ring_mem[ctr_addr];
      right_r  <= ring_mem[right_addr].rgb;
    end
  end

  // finished line store, written by stage two
  rgb_t          line_mem [MAX_WIDTH];
  rgb_t          line_a_r, line_b_r;
  logic          line_we;
  logic [CW-1:0] s1_col_r;
  rgb_t          result;

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[s1_col_r] <= result;
    end
    if (in_acc) begin
      line_a_r <= line_mem[line_a_addr];
      line_b_r <= line_mem[line_b_addr];
    end
  end

  // forwarding of a line write that coincides with the reads
  logic fwd_a_r, fwd_b_r;
  rgb_t fwd_rgb_r;

  // stage one item registers
  logic     s1_valid_r;
  nb_ctrl_t s1_ctrl_r;
  rgb_t     s1_v_r, s1_b1_r, s1_b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctrl_r <= ctrl_nxt;
      s1_col_r  <= col_r;
      s1_v_r    <= in_pix.rgb;
      s1_b1_r   <= last1_r;
      s1_b2_r   <= last2_r;
      fwd_a_r   <= line_we && (s1_col_r == line_a_addr);
      fwd_b_r   <= line_we && (s1_col_r == line_b_addr);
      fwd_rgb_r <= result;
    end
  end

  // --------------------------------------------------------------------------
  // stage two: neighbour sum and result
  // --------------------------------------------------------------------------
  rgb_t             up_mid, up_right;
  rgb_t             up_left_r, left_r;
  rgb_t             nb [8];
  logic [SUM_W-1:0] sum_red, sum_green, sum_blue;
  logic             out_valid_r, out_load;
  logic             out_end_r;
  rgb_t             out_rgb_r;

  assign up_mid   = fwd_b_r ? fwd_rgb_r : line_b_r;
  assign up_right = fwd_a_r ? fwd_rgb_r : line_a_r;

  // neighbours outside the frame count as zero
  always_comb begin
    nb[0] = (s1_ctrl_r.has_u && s1_ctrl_r.has_l) ? up_left_r : '0;
    nb[1] = s1_ctrl_r.has_u ? up_mid : '0;
    nb[2] = (s1_ctrl_r.has_u && s1_ctrl_r.has_r) ? up_right : '0;
    nb[3] = s1_ctrl_r.has_l ? left_r : '0;
    nb[4] = s1_ctrl_r.has_r ? right_r : '0;
    nb[5] = (s1_ctrl_r.has_d && s1_ctrl_r.has_l) ? s1_b2_r : '0;
    nb[6] = s1_ctrl_r.has_d ? s1_b1_r : '0;
    nb[7] = (s1_ctrl_r.has_d && s1_ctrl_r.has_r) ? s1_v_r : '0;
  end

  always_comb begin
    sum_red   = '0;
    sum_green = '0;
    sum_blue  = '0;
    for (int i = 0; i < 8; i++) begin
      sum_red   = sum_red + SUM_W'(nb[i].red);
      sum_green = sum_green + SUM_W'(nb[i].green);
      sum_blue  = sum_blue + SUM_W'(nb[i].blue);
    end
  end

  // painted pixels pass, holes take the average
  always_comb begin
    if (center_r.painted) begin
      result = center_r.rgb;
    end else begin
      result.red   = sum_red[SUM_W-1:3];
      result.green = sum_green[SUM_W-1:3];
      result.blue  = sum_blue[SUM_W-1:3];
    end
  end

  // items that release no pixel always move on
  assign s1_adv   = s1_valid_r && (!s1_ctrl_r.emit || !out_valid_r || out_ready);
  assign out_load = s1_adv && s1_ctrl_r.emit;
  assign line_we  = out_load;
  assign in_ready = !s1_valid_r || s1_adv;

  // left neighbour and row-above left neighbour for the next column
  always_ff @(posedge clk) begin
    if (out_load) begin
      left_r    <= result;
      up_left_r <= up_mid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rgb_r <= result;
      out_end_r <= s1_ctrl_r.frame_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_rgb_r.red;
  assign out_green_out = out_rgb_r.green;
  assign out_blue_out  = out_rgb_r.blue;
  assign out_frame_end = out_end_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // the frame end clears the row and the fill count
  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ctrl_nxt.frame_last |=> (row_r == '0) && (pcnt_r == '0))
    else $error("frame end did not clear row and fill count");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !out_load)
    else $error("output register overwritten while waiting");

  // line read data holds while the neighbour stage is stalled
  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> $stable(line_b_r) && $stable(center_r))
    else $error("line store read data changed during a stall");

  // ring write slot stays inside the ring
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    ws_r <= PW'(RING_DEPTH - 1))
    else $error("ring write slot out of range");

endmodule

>>> tb/sv/hole_fill_checker.sv
// ----------------------------------------------------------------------------
// hole_fill_checker
// Watches the pixel and result channels of the hole fill unit. It tracks
// the configuration writes, works out each finished pixel from its own copy
// of the line store and the pending ring, and compares every accepted result
// field by field against the oldest awaited pixel.
// ----------------------------------------------------------------------------
module hole_fill_checker
  import mnahf_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   in_command,
  input  logic [7:0]             in_red_in,
  input  logic [7:0]             in_green_in,
  input  logic [7:0]             in_blue_in,
  input  logic                   in_painted,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [7:0]             out_red_out,
  input  logic [7:0]             out_green_out,
  input  logic [7:0]             out_blue_out,
  input  logic                   out_frame_end,
  output int unsigned            fail_count,
  output int unsigned            expected_left
);

  localparam int RING_DEPTH = MAX_WIDTH + 1;

  typedef struct packed {
    rgb_t rgb;
    logic frame_end;
  } done_px_t;

  // register copies
  logic [WIDTH_CFG_W-1:0]  width_reg;
  logic [HEIGHT_CFG_W-1:0] height_reg;

  // finished row above, original pixels still pending, output position
  rgb_t        row_above [MAX_WIDTH];
  ring_entry_t recent_px [RING_DEPTH];
  int unsigned write_slot;
  int unsigned fill_level;
  int unsigned next_col;
  int unsigned next_row;
  rgb_t        left_px;

  done_px_t    awaited_px [$];
  int unsigned errors;

  // original pixel k places back in the ring
  function automatic ring_entry_t ring_back(input int unsigned k);
    return recent_px[(write_slot + RING_DEPTH - (k % RING_DEPTH)) % RING_DEPTH];
  endfunction

  function automatic void push_ring(input ring_entry_t e);
    recent_px[write_slot] = e;
    write_slot = (write_slot + 1) % RING_DEPTH;
  endfunction

  // one accepted item: may finish the pixel at the head of the ring
  task automatic advance_fill(input cmd_t cmd, input rgb_t px, input logic painted);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned sum_r;
    int unsigned sum_g;
    int unsigned sum_b;
    ring_entry_t v;
    ring_entry_t centre;
    rgb_t        nb [8];
    rgb_t        res;
    logic        has_l, has_r, has_u, has_d, last_col;
    done_px_t    done;

    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;

    // a padding tick is an unpainted black pixel
    if (cmd == CMD_PAD) begin
      v = '0;
    end else begin
      v.painted = painted;
      v.rgb     = px;
    end

    if (fill_level < w + 1) begin
      push_ring(v);
      fill_level++;
      return;
    end

    c = next_col % MAX_WIDTH;
    r = next_row;
    has_l = (c > 0);
    has_r = (c + 1 < w);
    has_u = (r > 0);
    has_d = (r + 1 < h);
    last_col = (c + 1 >= w);
    centre = ring_back(w + 1);

    // above and left already finished, right and below still original
    nb = '{default: '0};
    if (has_u) begin
      if (has_l) nb[0] = row_above[c - 1];
      nb[1] = row_above[c];
      if (has_r) nb[2] = row_above[c + 1];
    end
    if (has_l) nb[3] = left_px;
    if (has_r) nb[4] = ring_back(w).rgb;
    if (has_d) begin
      if (has_l) nb[5] = ring_back(2).rgb;
      nb[6] = ring_back(1).rgb;
      if (has_r) nb[7] = v.rgb;
    end

    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    foreach (nb[i]) begin
      sum_r += nb[i].red;
      sum_g += nb[i].green;
      sum_b += nb[i].blue;
    end

    if (centre.painted) begin
      res = centre.rgb;
    end else begin
      res.red   = 8'(sum_r >> 3);
      res.green = 8'(sum_g >> 3);
      res.blue  = 8'(sum_b >> 3);
    end

    // line store keeps finished values for the next row
    if (has_l) row_above[c - 1] = left_px;
    left_px = res;
    if (last_col) row_above[c] = res;

    done.rgb = res;
    done.frame_end = 1'b0;

    if (last_col) begin
      next_col = 0;
      if (r + 1 >= h) begin
        // frame end: ring emptied, this item is dropped
        done.frame_end = 1'b1;
        next_row = 0;
        fill_level = 0;
        awaited_px.push_back(done);
        return;
      end
      next_row = r + 1;
    end else begin
      next_col = c + 1;
    end

    awaited_px.push_back(done);
    push_ring(v);
  endtask

  always @(posedge clk) begin : track
    done_px_t want;

    if (!rst_n) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (row_above[i]) row_above[i] = '0;
      foreach (recent_px[i]) recent_px[i] = '0;
      write_slot = 0;
      fill_level = 0;
      next_col   = 0;
      next_row   = 0;
      left_px    = '0;
      awaited_px.delete();
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          CFG_IMAGE_WIDTH:  width_reg  = cfg_data[WIDTH_CFG_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_CFG_W-1:0];
          default: ;
        endcase
      end

      // compare finished pixels
      if (out_valid && out_ready) begin
        if (awaited_px.size() == 0) begin
          $error("unexpected result: red_out %0d green_out %0d blue_out %0d frame_end %0b",
                 out_red_out, out_green_out, out_blue_out, out_frame_end);
          errors++;
        end else begin
          want = awaited_px.pop_front();
          if (out_red_out !== want.rgb.red) begin
            $error("red_out: expected %0d, got %0d", want.rgb.red, out_red_out);
            errors++;
          end
          if (out_green_out !== want.rgb.green) begin
            $error("green_out: expected %0d, got %0d", want.rgb.green, out_green_out);
            errors++;
          end
          if (out_blue_out !== want.rgb.blue) begin
            $error("blue_out: expected %0d, got %0d", want.rgb.blue, out_blue_out);
            errors++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, out_frame_end);
            errors++;
          end
        end
      end

      // accepted item
      if (in_valid && in_ready) begin
        advance_fill(cmd_t'(in_command), rgb_t'({in_red_in, in_green_in, in_blue_in}),
                     in_painted);
      end
    end

    fail_count    <= errors;
    expected_left <= awaited_px.size();
  end

endmodule

>>> tb/sv/masked_neighbor_average_hole_fill_unit_tb.sv
// ----------------------------------------------------------------------------
// masked_neighbor_average_hole_fill_unit_tb
// Drives pixel frames through the hole fill unit: a frame of the widest random
// size that writes every line store entry later frames read, short directed
// frames for the corner cases, then random frames of small size with random
// content and broken padding. The sender works in bursts and the receiver
// stalls on its own; a checker beside the unit predicts and compares every
// finished pixel.
// ----------------------------------------------------------------------------
module masked_neighbor_average_hole_fill_unit_tb;
  import mnahf_pkg::*;

  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PULSE
  } rx_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic       in_valid    = 1'b0;
  logic       in_command  = CMD_PIXEL;
  logic [7:0] in_red_in   = '0;
  logic [7:0] in_green_in = '0;
  logic [7:0] in_blue_in  = '0;
  logic       in_painted  = 1'b0;
  logic       in_ready;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red_out;
  logic [7:0] out_green_out;
  logic [7:0] out_blue_out;
  logic       out_frame_end;

  int unsigned fail_count;
  int unsigned expected_left;

  // sender state
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned cur_w = 1;
  int unsigned cur_h = 1;

  // receiver state
  rx_mode_t    rx_mode   = RX_OPEN;
  int unsigned rx_left   = 0;
  int unsigned rx_tick   = 0;
  int unsigned hold_left = 0;
  logic        hold_req  = 1'b0;
  logic        hold_seen = 1'b0;

  masked_neighbor_average_hole_fill_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .in_painted   (in_painted),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .out_frame_end(out_frame_end)
  );

  hole_fill_checker fill_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .in_painted   (in_painted),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .out_frame_end(out_frame_end),
    .fail_count   (fail_count),
    .expected_left(expected_left)
  );

  always #2 clk = ~clk;

  // receiver: changing stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(16, 160);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
        default:   out_ready <= ((rx_tick % 5) < 3);
      endcase
    end
  end

  // channel value biased towards the extremes
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic rgb_t rand_rgb();
    rgb_t px;
    px.red   = rand_chan();
    px.green = rand_chan();
    px.blue  = rand_chan();
    return px;
  endfunction

  // offer one item, with a random gap between bursts
  task automatic offer_item(input cmd_t cmd, input rgb_t px, input logic painted);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_red_in   <= px.red;
    in_green_in <= px.green;
    in_blue_in  <= px.blue;
    in_painted  <= painted;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // stop sending and wait until every finished pixel has come out
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write both geometry registers, keep the clamped sizes for framing
  task automatic set_geometry(input int unsigned w, input int unsigned h);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_w = (w == 0) ? 1 : (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
    cur_h = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endtask

  // random frame pixels, the odd padding tick among them, then padding
  task automatic send_frame(input int unsigned n_px, input int unsigned n_pad);
    for (int unsigned i = 0; i < n_px; i++) begin
      offer_item(($urandom_range(0, 31) == 0) ? CMD_PAD : CMD_PIXEL, rand_rgb(),
                 1'($urandom_range(0, 2) == 0));
    end
    for (int unsigned i = 0; i < n_pad; i++) begin
      offer_item(CMD_PAD, rand_rgb(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stimulus
    int unsigned frame_no;
    int unsigned random_start;
    int unsigned w;
    int unsigned h;
    int unsigned n_pad;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // widest random frame first: every line store entry read later is written
    set_geometry(40, 2);
    send_frame(cur_w * cur_h, cur_w + 1);
    drain_all();

    // 3x2 frame: extremes, painted and holes, a padding tick inside the frame
    set_geometry(3, 2);
    offer_item(CMD_PIXEL, rgb_t'{8'hff, 8'hff, 8'hff}, 1'b1);
    offer_item(CMD_PIXEL, rgb_t'{8'h00, 8'h00, 8'h00}, 1'b0);
    offer_item(CMD_PIXEL, rgb_t'{8'hff, 8'h00, 8'hff}, 1'b0);
    offer_item(CMD_PAD,   rgb_t'{8'h5a, 8'ha5, 8'hff}, 1'b1);
    offer_item(CMD_PIXEL, rgb_t'{8'hff, 8'hff, 8'hff}, 1'b0);
    offer_item(CMD_PIXEL, rgb_t'{8'h00, 8'hff, 8'h00}, 1'b1);
    repeat (4) offer_item(CMD_PAD, rgb_t'{8'h00, 8'h00, 8'h00}, 1'b0);
    drain_all();

    // zero width and height clamp to a single pixel
    set_geometry(0, 0);
    offer_item(CMD_PIXEL, rgb_t'{8'h80, 8'h40, 8'h20}, 1'b0);
    repeat (2) offer_item(CMD_PAD, rand_rgb(), 1'b1);
    drain_all();

    // too few padding ticks, then a geometry change within the frame
    set_geometry(2, 2);
    repeat (4) offer_item(CMD_PIXEL, rand_rgb(), 1'b0);
    offer_item(CMD_PAD, rand_rgb(), 1'b0);
    drain_all();
    set_geometry(1, 3);
    repeat (3) offer_item(CMD_PIXEL, rand_rgb(), 1'($urandom_range(0, 1)));
    repeat (2) offer_item(CMD_PAD, rand_rgb(), 1'b0);
    drain_all();

    // random frames
    frame_no = 0;
    random_start = items_sent;
    while (items_sent - random_start < 560) begin
      if (frame_no == 0) begin
        // receiver holds off while the frame keeps coming
        drain_all();
        set_geometry(8, 6);
        hold_req <= ~hold_req;
      end else if ($urandom_range(0, 2) != 0) begin
        drain_all();
        case ($urandom_range(0, 19))
          0: begin
            w = 0;
            h = $urandom_range(0, 6);
          end
          1, 2, 3: begin
            w = $urandom_range(9, 40);
            h = $urandom_range(1, 4);
          end
          default: begin
            w = $urandom_range(1, 8);
            h = $urandom_range(0, 8);
          end
        endcase
        set_geometry(w, h);
      end

      // mostly full padding, sometimes short or extra
      n_pad = cur_w + 1;
      case ($urandom_range(0, 9))
        0: n_pad = $urandom_range(0, cur_w);
        1: n_pad = cur_w + 1 + $urandom_range(1, 3);
        default: ;
      endcase
      send_frame(cur_w * cur_h, n_pad);
      frame_no++;
    end

    drain_all();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("masked_neighbor_average_hole_fill_unit: match");
    end else begin
      $display("masked_neighbor_average_hole_fill_unit: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("masked_neighbor_average_hole_fill_unit: mismatch");
    $finish;
  end

endmodule

>>> sim.f
src/mnahf_pkg.sv
src/masked_neighbor_average_hole_fill_unit.sv
tb/sv/hole_fill_checker.sv
tb/sv/masked_neighbor_average_hole_fill_unit_tb.sv
